/* design/mreb_pkg.sv */
// mreb_pkg: shared types and constants for the mesh root election beacon block
// used by every file of the block, depends on nothing
`default_nettype none

package mreb_pkg;

    // widths of the item fields
    localparam int unsigned ID_W   = 32;
    localparam int unsigned SEQ_W  = 16;
    localparam int unsigned HOPS_W = 16;
    localparam int unsigned LEN_W  = 11;
    localparam int unsigned MAC_W  = 48;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned TICK_W = 8;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE_ID        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_PERIOD      = 2'd2;

    // reset values of the configuration registers
    localparam logic [ID_W-1:0]   OWN_NODE_ID_RESET  = 32'd1;
    localparam logic [TICK_W-1:0] ROOT_TIMEOUT_RESET = 8'd5;
    localparam logic [TICK_W-1:0] BEACON_PERIOD_RESET = 8'd3;

    // protocol constants
    localparam logic [SEQ_W-1:0] SEQ_HALF         = 16'h7fff;
    localparam logic [LEN_W-1:0] VALID_BEACON_LEN = 11'd13;

    // command codes of the input item
    localparam logic CMD_BEACON = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // action codes of the result item
    typedef enum logic [1:0] {
        ACT_NONE        = 2'd0,
        ACT_REBROADCAST = 2'd1,
        ACT_OWN         = 2'd2
    } action_t;

    // class of a queued item
    typedef enum logic [1:0] {
        KIND_IGNORE = 2'd0,
        KIND_BEACON = 2'd1,
        KIND_TICK   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [ID_W-1:0]   own_node_id;
        logic [TICK_W-1:0] root_timeout_ticks;
        logic [TICK_W-1:0] beacon_period_ticks;
    } cfg_t;

    // classified item passed from the front to the back
    typedef struct packed {
        kind_t             kind;
        logic              feed;
        logic [ID_W-1:0]   root_id;
        logic [SEQ_W-1:0]  seq;
        logic [HOPS_W-1:0] hops_inc;
        logic [ID_W-1:0]   fwd_node_id;
        logic [MAC_W-1:0]  mac;
    } work_t;

endpackage

`default_nettype wire

/* design/mreb_if.sv */
// mreb_req_if / mreb_rsp_if: valid/ready channels carrying input and result items
// depends on mreb_pkg for the field widths
`default_nettype none

interface mreb_req_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [mreb_pkg::LEN_W-1:0]     packet_length;
    logic [mreb_pkg::ID_W-1:0]      beacon_root_id;
    logic [mreb_pkg::SEQ_W-1:0]     beacon_seq;
    logic [mreb_pkg::HOPS_W-1:0]    beacon_hops;
    logic [mreb_pkg::ID_W-1:0]      beacon_sender_id;
    logic [mreb_pkg::MAC_W-1:0]     sender_mac;

    modport source (
        output valid, command, packet_length, beacon_root_id, beacon_seq,
               beacon_hops, beacon_sender_id, sender_mac,
        input  ready
    );
    modport sink (
        input  valid, command, packet_length, beacon_root_id, beacon_seq,
               beacon_hops, beacon_sender_id, sender_mac,
        output ready
    );
endinterface

interface mreb_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     action;
    logic [mreb_pkg::ID_W-1:0]      out_root_id;
    logic [mreb_pkg::SEQ_W-1:0]     out_seq;
    logic [mreb_pkg::HOPS_W-1:0]    out_hops;
    logic [mreb_pkg::ID_W-1:0]      out_sender_id;
    logic                           neighbor_feed;
    logic [mreb_pkg::ID_W-1:0]      current_root;
    logic [mreb_pkg::HOPS_W-1:0]    current_hops;
    logic [mreb_pkg::MAC_W-1:0]     current_next_hop;

    modport source (
        output valid, action, out_root_id, out_seq, out_hops, out_sender_id,
               neighbor_feed, current_root, current_hops, current_next_hop,
        input  ready
    );
    modport sink (
        input  valid, action, out_root_id, out_seq, out_hops, out_sender_id,
               neighbor_feed, current_root, current_hops, current_next_hop,
        output ready
    );
endinterface

`default_nettype wire

/* design/mreb_front.sv */
// mreb_front: accepts input items and classifies them into tick, beacon or ignored
// depends on mreb_pkg and mreb_req_if
`default_nettype none

module mreb_front (
    mreb_req_if.sink                req,
    input  wire mreb_pkg::cfg_t     cfg,
    input  wire logic               q_ready,
    output logic                    push,
    output mreb_pkg::work_t         work
);

    logic len_ok;
    logic foreign_root;

    // accept whenever the queue has room
    assign req.ready = q_ready;
    assign push      = req.valid & q_ready;

    // beacon checks that need no root state
    assign len_ok       = (req.packet_length == mreb_pkg::VALID_BEACON_LEN);
    assign foreign_root = (req.beacon_root_id != cfg.own_node_id);

    // classify and precompute the incremented hop count
    always_comb
    begin
        work.root_id     = req.beacon_root_id;
        work.seq         = req.beacon_seq;
        work.hops_inc    = req.beacon_hops + mreb_pkg::HOPS_W'(1);
        work.fwd_node_id = req.beacon_sender_id;
        work.mac         = req.sender_mac;
        work.feed        = 1'b0;
        if (req.command == mreb_pkg::CMD_TICK)
        begin
            work.kind = mreb_pkg::KIND_TICK;
        end
        else if (len_ok && foreign_root)
        begin
            work.kind = mreb_pkg::KIND_BEACON;
            work.feed = (req.beacon_hops != '0) &&
                        (req.beacon_sender_id != cfg.own_node_id);
        end
        else
        begin
            work.kind = mreb_pkg::KIND_IGNORE;
        end
    end

endmodule

`default_nettype wire

/* design/mreb_queue.sv */
// mreb_queue: short fifo of classified items between the front and the back
// depends on mreb_pkg
`default_nettype none

module mreb_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire mreb_pkg::work_t    push_work,
    output logic                    not_full,
    input  wire logic               pop,
    output logic                    q_valid,
    output mreb_pkg::work_t         head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    mreb_pkg::work_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_full = (count_reg != FULL_CNT);
    assign q_valid  = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_work;
        end
    end

endmodule

`default_nettype wire

/* design/mreb_back.sv */
// mreb_back: holds the root state, runs the election and timers, registers results
// depends on mreb_pkg and mreb_rsp_if
`default_nettype none

module mreb_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mreb_pkg::cfg_t     cfg,
    input  wire logic               q_valid,
    input  wire mreb_pkg::work_t    work,
    output logic                    pop,
    mreb_rsp_if.source              rsp
);

    localparam int unsigned ID_W   = mreb_pkg::ID_W;
    localparam int unsigned SEQ_W  = mreb_pkg::SEQ_W;
    localparam int unsigned HOPS_W = mreb_pkg::HOPS_W;
    localparam int unsigned MAC_W  = mreb_pkg::MAC_W;
    localparam int unsigned TIME_W = mreb_pkg::TIME_W;
    localparam int unsigned TICK_W = mreb_pkg::TICK_W;

    // root state
    logic [TIME_W-1:0] time_now_reg,     time_now_next;
    logic [ID_W-1:0]   root_id_reg,      root_id_next;
    logic [SEQ_W-1:0]  root_seq_reg,     root_seq_next;
    logic [HOPS_W-1:0] root_hops_reg,    root_hops_next;
    logic [MAC_W-1:0]  root_nh_reg,      root_nh_next;
    logic [TIME_W-1:0] root_upd_reg,     root_upd_next;
    logic [SEQ_W-1:0]  own_seq_reg,      own_seq_next;
    logic [TIME_W-1:0] last_beacon_reg,  last_beacon_next;
    logic              sent_once_reg,    sent_once_next;

    // result register
    logic              res_valid_reg;
    mreb_pkg::action_t action_reg,  action_next;
    logic [ID_W-1:0]   o_id_reg,    o_id_next;
    logic [SEQ_W-1:0]  o_seq_reg,   o_seq_next;
    logic [HOPS_W-1:0] o_hops_reg,  o_hops_next;
    logic [ID_W-1:0]   o_snd_reg,   o_snd_next;
    logic              feed_reg,    feed_next;
    logic [ID_W-1:0]   cur_id_reg;
    logic [HOPS_W-1:0] cur_hops_reg;
    logic [MAC_W-1:0]  cur_nh_reg;

    // working values
    logic [TIME_W-1:0] tick_time;
    logic              stale;
    logic              self_root;
    logic              send_own;
    logic              id_greater;
    logic              id_equal;
    logic [SEQ_W-1:0]  diff_held_new;
    logic [SEQ_W-1:0]  diff_new_held;
    logic              seq_newer;
    logic              take;

    // next item runs when the result register is free or being drained
    assign pop = q_valid & (~res_valid_reg | rsp.ready);

    // tick timing terms
    assign tick_time = time_now_reg + TIME_W'(1);
    assign stale     = (root_id_reg != cfg.own_node_id) &&
                       ((tick_time - root_upd_reg) >=
                        {{(TIME_W-TICK_W){1'b0}}, cfg.root_timeout_ticks});
    assign self_root = stale || (root_id_reg == cfg.own_node_id);
    assign send_own  = self_root &&
                       !(sent_once_reg && ((tick_time - last_beacon_reg) <
                         {{(TIME_W-TICK_W){1'b0}}, cfg.beacon_period_ticks}));

    // election terms, serial number compare on the sequence
    assign id_greater    = (work.root_id > root_id_reg);
    assign id_equal      = (work.root_id == root_id_reg);
    assign diff_held_new = root_seq_reg - work.seq;
    assign diff_new_held = work.seq - root_seq_reg;
    assign seq_newer     = (root_seq_reg >= work.seq) ? (diff_held_new > mreb_pkg::SEQ_HALF)
                                                      : (diff_new_held < mreb_pkg::SEQ_HALF);
    assign take          = id_greater ||
                           (id_equal && seq_newer && (work.hops_inc <= root_hops_reg));

    // state and result update for the item at the queue head
    always_comb
    begin
        time_now_next    = time_now_reg;
        root_id_next     = root_id_reg;
        root_seq_next    = root_seq_reg;
        root_hops_next   = root_hops_reg;
        root_nh_next     = root_nh_reg;
        root_upd_next    = root_upd_reg;
        own_seq_next     = own_seq_reg;
        last_beacon_next = last_beacon_reg;
        sent_once_next   = sent_once_reg;
        action_next      = mreb_pkg::ACT_NONE;
        o_id_next        = '0;
        o_seq_next       = '0;
        o_hops_next      = '0;
        o_snd_next       = '0;
        feed_next        = work.feed;
        unique case (work.kind)
            mreb_pkg::KIND_TICK:
            begin
                time_now_next = tick_time;
                if (stale)
                begin
                    root_id_next   = cfg.own_node_id;
                    root_seq_next  = '0;
                    root_hops_next = '0;
                    root_nh_next   = '0;
                    root_upd_next  = tick_time;
                end
                if (send_own)
                begin
                    last_beacon_next = tick_time;
                    sent_once_next   = 1'b1;
                    action_next      = mreb_pkg::ACT_OWN;
                    o_id_next        = root_id_next;
                    o_seq_next       = own_seq_reg;
                    own_seq_next     = own_seq_reg + SEQ_W'(1);
                    root_seq_next    = own_seq_reg;
                    root_upd_next    = tick_time;
                end
            end
            mreb_pkg::KIND_BEACON:
            begin
                if (take)
                begin
                    root_id_next   = work.root_id;
                    root_nh_next   = work.mac;
                    root_hops_next = work.hops_inc;
                    root_seq_next  = work.seq;
                    root_upd_next  = time_now_reg;
                    action_next    = mreb_pkg::ACT_REBROADCAST;
                    o_id_next      = work.root_id;
                    o_seq_next     = work.seq;
                    o_hops_next    = work.hops_inc + HOPS_W'(1);
                    o_snd_next     = work.fwd_node_id;
                end
            end
            mreb_pkg::KIND_IGNORE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // control state and root state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg    <= '0;
            root_id_reg     <= mreb_pkg::OWN_NODE_ID_RESET;
            root_seq_reg    <= '0;
            root_hops_reg   <= '0;
            root_nh_reg     <= '0;
            root_upd_reg    <= '0;
            own_seq_reg     <= '0;
            last_beacon_reg <= '0;
            sent_once_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                time_now_reg    <= time_now_next;
                root_id_reg     <= root_id_next;
                root_seq_reg    <= root_seq_next;
                root_hops_reg   <= root_hops_next;
                root_nh_reg     <= root_nh_next;
                root_upd_reg    <= root_upd_next;
                own_seq_reg     <= own_seq_next;
                last_beacon_reg <= last_beacon_next;
                sent_once_reg   <= sent_once_next;
                res_valid_reg   <= 1'b1;
            end
            else if (rsp.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            action_reg   <= action_next;
            o_id_reg     <= o_id_next;
            o_seq_reg    <= o_seq_next;
            o_hops_reg   <= o_hops_next;
            o_snd_reg    <= o_snd_next;
            feed_reg     <= feed_next;
            cur_id_reg   <= root_id_next;
            cur_hops_reg <= root_hops_next;
            cur_nh_reg   <= root_nh_next;
        end
    end

    assign rsp.valid            = res_valid_reg;
    assign rsp.action           = action_reg;
    assign rsp.out_root_id      = o_id_reg;
    assign rsp.out_seq          = o_seq_reg;
    assign rsp.out_hops         = o_hops_reg;
    assign rsp.out_sender_id    = o_snd_reg;
    assign rsp.neighbor_feed    = feed_reg;
    assign rsp.current_root     = cur_id_reg;
    assign rsp.current_hops     = cur_hops_reg;
    assign rsp.current_next_hop = cur_nh_reg;

endmodule

`default_nettype wire

/* design/mesh_root_election_beacon.sv */
// mesh_root_election_beacon: top level, configuration registers and block wiring
// depends on mreb_pkg, mreb_if, mreb_front, mreb_queue, mreb_back
//
// Root election by highest node id with 16-bit serial sequence numbers. Each
// input item is a received root beacon (command 0) or a one-second tick
// (command 1) and gives exactly one result item: the beacon to send, if any,
// the neighbor feed flag and the root held afterwards. The block takes one item
// per clock while the queue has room; the back end updates the root state for
// one item per cycle while its result register is free or drained. A short queue
// between the classifying front end and the back end, and the result register,
// let either side stall without stopping the other. The configuration registers
// (own node id, root timeout, beacon period) must be written by the user through
// cfg_we/cfg_index/cfg_data only while no item is in flight; it is not enforced.
// An index beyond the register list is ignored. No clearing pass follows reset.
`default_nettype none

module mesh_root_election_beacon #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    mreb_req_if.sink                                req,
    mreb_rsp_if.source                              rsp,
    input  wire logic                               cfg_we,
    input  wire logic [mreb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mreb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    mreb_pkg::cfg_t  cfg_reg;
    mreb_pkg::work_t push_work;
    mreb_pkg::work_t head_work;
    logic            push;
    logic            q_not_full;
    logic            q_valid;
    logic            pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_node_id         <= mreb_pkg::OWN_NODE_ID_RESET;
            cfg_reg.root_timeout_ticks  <= mreb_pkg::ROOT_TIMEOUT_RESET;
            cfg_reg.beacon_period_ticks <= mreb_pkg::BEACON_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mreb_pkg::CFG_OWN_NODE_ID:
                begin
                    cfg_reg.own_node_id <= cfg_data[mreb_pkg::ID_W-1:0];
                end
                mreb_pkg::CFG_ROOT_TIMEOUT_TICKS:
                begin
                    cfg_reg.root_timeout_ticks <= cfg_data[mreb_pkg::TICK_W-1:0];
                end
                mreb_pkg::CFG_BEACON_PERIOD:
                begin
                    cfg_reg.beacon_period_ticks <= cfg_data[mreb_pkg::TICK_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // front end: accept and classify
    mreb_front u_front (
        .req     (req),
        .cfg     (cfg_reg),
        .q_ready (q_not_full),
        .push    (push),
        .work    (push_work)
    );

    // queue between front and back
    mreb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_work (push_work),
        .not_full  (q_not_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .head      (head_work)
    );

    // back end: election, timers, result register
    mreb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .work    (head_work),
        .pop     (pop),
        .rsp     (rsp)
    );

`ifndef SYNTH
    // an accepted item is waiting in the queue at the next edge
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> q_valid)
        else $error("accepted item missing from queue");

    // an own beacon carries no hops and no sender
    a_own_beacon_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.action == mreb_pkg::ACT_OWN)) |->
        ((rsp.out_hops == '0) && (rsp.out_sender_id == '0)))
        else $error("own beacon with nonzero hops or sender");

    // a rebroadcast reflects the root just taken, one hop further
    a_rebroadcast_root: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.action == mreb_pkg::ACT_REBROADCAST)) |->
        ((rsp.current_root == rsp.out_root_id) &&
         (rsp.out_hops == (rsp.current_hops + mreb_pkg::HOPS_W'(1)))))
        else $error("rebroadcast does not match held root");
`endif

endmodule

`default_nettype wire

/* dv/tb_mesh_root_election_beacon.sv */
// tb_mesh_root_election_beacon: self-checking testbench for mesh_root_election_beacon
// predicts every result item from its own root election model, checks field by field
// depends on mreb_pkg, mreb_if and the design top level
`timescale 1ns / 1ps

module tb_mesh_root_election_beacon;

    localparam int unsigned ID_W       = mreb_pkg::ID_W;
    localparam int unsigned SEQ_W      = mreb_pkg::SEQ_W;
    localparam int unsigned HOPS_W     = mreb_pkg::HOPS_W;
    localparam int unsigned LEN_W      = mreb_pkg::LEN_W;
    localparam int unsigned MAC_W      = mreb_pkg::MAC_W;
    localparam int unsigned TIME_W     = mreb_pkg::TIME_W;
    localparam int unsigned TICK_W     = mreb_pkg::TICK_W;
    localparam int unsigned CFG_IDX_W  = mreb_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = mreb_pkg::CFG_DATA_W;

    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned TIMEOUT_NS   = 400_000;
    // index past the register list, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic              command;
        logic [LEN_W-1:0]  packet_length;
        logic [ID_W-1:0]   beacon_root_id;
        logic [SEQ_W-1:0]  beacon_seq;
        logic [HOPS_W-1:0] beacon_hops;
        logic [ID_W-1:0]   beacon_sender_id;
        logic [MAC_W-1:0]  sender_mac;
    } beacon_item_t;

    typedef struct packed {
        mreb_pkg::action_t action;
        logic [ID_W-1:0]   out_root_id;
        logic [SEQ_W-1:0]  out_seq;
        logic [HOPS_W-1:0] out_hops;
        logic [ID_W-1:0]   out_sender_id;
        logic              neighbor_feed;
        logic [ID_W-1:0]   current_root;
        logic [HOPS_W-1:0] current_hops;
        logic [MAC_W-1:0]  current_next_hop;
    } beacon_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mreb_req_if req_ch ();
    mreb_rsp_if rsp_ch ();

    mesh_root_election_beacon DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // stimulus and expectation stores
    beacon_item_t   pending_items[$];
    beacon_result_t expected_results[$];
    beacon_item_t   drive_item;
    beacon_item_t   taken_item;
    bit             req_taken;
    int unsigned    send_idle_pct;
    int unsigned    stall_pct;
    bit             hold_req;
    bit             rsp_hold_on;
    int unsigned    mismatches;

    // predictor configuration
    logic [ID_W-1:0]   own_id_cfg;
    logic [TICK_W-1:0] timeout_cfg;
    logic [TICK_W-1:0] period_cfg;

    // predictor state
    logic [TIME_W-1:0] clock_secs;
    logic [ID_W-1:0]   root_id_q;
    logic [SEQ_W-1:0]  root_seq_q;
    logic [HOPS_W-1:0] root_hops_q;
    logic [MAC_W-1:0]  root_mac_q;
    logic [TIME_W-1:0] root_time_q;
    logic [SEQ_W-1:0]  own_seq_q;
    logic [TIME_W-1:0] last_beacon_q;
    logic              beacon_sent;

    // stimulus shaping
    logic [ID_W-1:0]  id_pool [4];
    logic [SEQ_W-1:0] seq_base;

    // clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void root_to_self();
        root_mac_q  = '0;
        root_id_q   = own_id_cfg;
        root_seq_q  = '0;
        root_hops_q = '0;
        root_time_q = clock_secs;
    endfunction

    function automatic void reset_election();
        own_id_cfg    = mreb_pkg::OWN_NODE_ID_RESET;
        timeout_cfg   = mreb_pkg::ROOT_TIMEOUT_RESET;
        period_cfg    = mreb_pkg::BEACON_PERIOD_RESET;
        clock_secs    = '0;
        root_to_self();
        own_seq_q     = '0;
        last_beacon_q = '0;
        beacon_sent   = 1'b0;
    endfunction

    // 16-bit serial number compare, equal is not newer
    function automatic logic seq_newer(logic [SEQ_W-1:0] held, logic [SEQ_W-1:0] incoming);
        logic [SEQ_W-1:0] diff;
        if (held >= incoming)
        begin
            diff = held - incoming;
            return diff > mreb_pkg::SEQ_HALF;
        end
        diff = incoming - held;
        return diff < mreb_pkg::SEQ_HALF;
    endfunction

    // one election step: updates the held root and returns the result item
    function automatic beacon_result_t elect_root(beacon_item_t it);
        beacon_result_t   r;
        logic [HOPS_W-1:0] h;
        logic             take;
        r = '0;
        r.action = mreb_pkg::ACT_NONE;
        if (it.command == mreb_pkg::CMD_TICK)
        begin
            clock_secs = clock_secs + 1'b1;
            // stale foreign root falls back to self
            if (root_id_q != own_id_cfg &&
                TIME_W'(clock_secs - root_time_q) >= TIME_W'(timeout_cfg))
                root_to_self();
            // own beacon once per period while self is root
            if (root_id_q == own_id_cfg &&
                !(beacon_sent && TIME_W'(clock_secs - last_beacon_q) < TIME_W'(period_cfg)))
            begin
                last_beacon_q = clock_secs;
                beacon_sent   = 1'b1;
                r.action      = mreb_pkg::ACT_OWN;
                r.out_root_id = root_id_q;
                r.out_seq     = own_seq_q;
                own_seq_q     = own_seq_q + 1'b1;
                root_seq_q    = r.out_seq;
                root_time_q   = clock_secs;
            end
        end
        else if (it.packet_length == mreb_pkg::VALID_BEACON_LEN &&
                 it.beacon_root_id != own_id_cfg)
        begin
            h = it.beacon_hops + 1'b1;
            take = 1'b0;
            r.neighbor_feed = (it.beacon_hops != '0) && (it.beacon_sender_id != own_id_cfg);
            if (it.beacon_root_id > root_id_q)
            begin
                take = 1'b1;
                root_id_q = it.beacon_root_id;
            end
            else if (it.beacon_root_id == root_id_q)
                take = seq_newer(root_seq_q, it.beacon_seq) && (h <= root_hops_q);
            if (take)
            begin
                root_mac_q      = it.sender_mac;
                root_hops_q     = h;
                root_seq_q      = it.beacon_seq;
                root_time_q     = clock_secs;
                r.action        = mreb_pkg::ACT_REBROADCAST;
                r.out_root_id   = it.beacon_root_id;
                r.out_seq       = it.beacon_seq;
                r.out_hops      = h + 1'b1;
                r.out_sender_id = it.beacon_sender_id;
            end
        end
        r.current_root     = root_id_q;
        r.current_hops     = root_hops_q;
        r.current_next_hop = root_mac_q;
        return r;
    endfunction

    function automatic void cmp_field(string name, logic [63:0] exp, logic [63:0] got);
        if (got !== exp)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h got %0h", $realtime, name, exp, got);
        end
    endfunction

    // item acceptance, prediction and result checking
    always @(posedge clk)
    begin
        beacon_result_t exp;
        req_taken = (req_ch.valid === 1'b1) && (req_ch.ready === 1'b1);
        if (req_taken)
        begin
            taken_item.command          = req_ch.command;
            taken_item.packet_length    = req_ch.packet_length;
            taken_item.beacon_root_id   = req_ch.beacon_root_id;
            taken_item.beacon_seq       = req_ch.beacon_seq;
            taken_item.beacon_hops      = req_ch.beacon_hops;
            taken_item.beacon_sender_id = req_ch.beacon_sender_id;
            taken_item.sender_mac       = req_ch.sender_mac;
            expected_results.push_back(elect_root(taken_item));
        end
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result item with nothing expected", $realtime);
            end
            else
            begin
                exp = expected_results.pop_front();
                cmp_field("action", exp.action, rsp_ch.action);
                cmp_field("out_root_id", exp.out_root_id, rsp_ch.out_root_id);
                cmp_field("out_seq", exp.out_seq, rsp_ch.out_seq);
                cmp_field("out_hops", exp.out_hops, rsp_ch.out_hops);
                cmp_field("out_sender_id", exp.out_sender_id, rsp_ch.out_sender_id);
                cmp_field("neighbor_feed", exp.neighbor_feed, rsp_ch.neighbor_feed);
                cmp_field("current_root", exp.current_root, rsp_ch.current_root);
                cmp_field("current_hops", exp.current_hops, rsp_ch.current_hops);
                cmp_field("current_next_hop", exp.current_next_hop, rsp_ch.current_next_hop);
            end
        end
    end

    // input driver, fed from the pending queue
    always @(negedge clk)
    begin
        if (req_ch.valid !== 1'b1 || req_taken)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drive_item = pending_items.pop_front();
                req_ch.valid            <= 1'b1;
                req_ch.command          <= drive_item.command;
                req_ch.packet_length    <= drive_item.packet_length;
                req_ch.beacon_root_id   <= drive_item.beacon_root_id;
                req_ch.beacon_seq       <= drive_item.beacon_seq;
                req_ch.beacon_hops      <= drive_item.beacon_hops;
                req_ch.beacon_sender_id <= drive_item.beacon_sender_id;
                req_ch.sender_mac       <= drive_item.sender_mac;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result receiver with random stalls and the long hold-off
    always @(negedge clk)
    begin
        rsp_ch.ready <= !rsp_hold_on && ($urandom_range(99) >= stall_pct);
    end

    // long hold-off, counted in clock cycles
    initial
    begin
        forever
        begin
            wait (hold_req);
            @(posedge clk);
            rsp_hold_on = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rsp_hold_on = 1'b0;
            hold_req = 1'b0;
        end
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_mesh_root_election_beacon: FAIL");
        $finish;
    end

    function automatic beacon_item_t beacon(logic [ID_W-1:0] id, logic [SEQ_W-1:0] seq,
                                            logic [HOPS_W-1:0] hops, logic [ID_W-1:0] sender,
                                            logic [MAC_W-1:0] mac, logic [LEN_W-1:0] len);
        beacon_item_t it;
        it.command          = mreb_pkg::CMD_BEACON;
        it.packet_length    = len;
        it.beacon_root_id   = id;
        it.beacon_seq       = seq;
        it.beacon_hops      = hops;
        it.beacon_sender_id = sender;
        it.sender_mac       = mac;
        return it;
    endfunction

    // tick with random payload, which the block must ignore
    function automatic beacon_item_t tick_item();
        beacon_item_t it;
        it = beacon($urandom, 16'($urandom), 16'($urandom), $urandom,
                    {16'($urandom), 32'($urandom)}, 11'($urandom_range(1500)));
        it.command = mreb_pkg::CMD_TICK;
        return it;
    endfunction

    // mostly well-formed beacons around a few competing roots, some ticks and noise
    function automatic beacon_item_t rand_item();
        beacon_item_t it;
        int unsigned roll;
        roll = $urandom_range(99);
        if ($urandom_range(9) == 0)
            seq_base = seq_base + (($urandom_range(1) == 1) ? 16'h7fff : 16'h8000);
        else
            seq_base = seq_base + 16'($urandom_range(2));
        it = beacon(id_pool[$urandom_range(3)], seq_base - 16'($urandom_range(2)),
                    ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3)),
                    ($urandom_range(9) == 0) ? own_id_cfg : 32'($urandom),
                    {16'($urandom), 32'($urandom)}, mreb_pkg::VALID_BEACON_LEN);
        if (roll < 25)
            it = tick_item();
        else if (roll < 32)
            it.packet_length = 11'($urandom_range(1500));
        else if (roll < 37)
            it.beacon_root_id = own_id_cfg;
        else if (roll < 40)
            it.beacon_root_id = $urandom;
        return it;
    endfunction

    function automatic void refresh_pool();
        id_pool[0] = own_id_cfg + 1'b1;
        id_pool[1] = own_id_cfg - 1'b1;
        id_pool[2] = $urandom;
        id_pool[3] = '1;
        seq_base   = 16'($urandom);
    endfunction

    function automatic void push_random(int unsigned count);
        repeat (count) pending_items.push_back(rand_item());
    endfunction

    // register write, only while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            mreb_pkg::CFG_OWN_NODE_ID:        own_id_cfg  = val;
            mreb_pkg::CFG_ROOT_TIMEOUT_TICKS: timeout_cfg = val[TICK_W-1:0];
            mreb_pkg::CFG_BEACON_PERIOD:      period_cfg  = val[TICK_W-1:0];
            default:                          ;
        endcase
    endtask

    task automatic configure(logic [ID_W-1:0] own_id, logic [TICK_W-1:0] timeout,
                             logic [TICK_W-1:0] period);
        write_reg(mreb_pkg::CFG_OWN_NODE_ID, own_id);
        write_reg(mreb_pkg::CFG_ROOT_TIMEOUT_TICKS, CFG_DATA_W'(timeout));
        write_reg(mreb_pkg::CFG_BEACON_PERIOD, CFG_DATA_W'(period));
        refresh_pool();
    endtask

    // wait until every item is taken and every result has come back
    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0 ||
               req_ch.valid === 1'b1)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        req_ch.valid            = 1'b0;
        req_ch.command          = mreb_pkg::CMD_BEACON;
        req_ch.packet_length    = '0;
        req_ch.beacon_root_id   = '0;
        req_ch.beacon_seq       = '0;
        req_ch.beacon_hops      = '0;
        req_ch.beacon_sender_id = '0;
        req_ch.sender_mac       = '0;
        rsp_ch.ready            = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = mreb_pkg::CFG_OWN_NODE_ID;
        cfg_data                = '0;
        send_idle_pct           = 0;
        stall_pct               = 0;
        hold_req                = 1'b0;
        rsp_hold_on             = 1'b0;
        req_taken               = 1'b0;
        mismatches              = 0;
        reset_election();
        refresh_pool();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at reset configuration, own id 1
        pending_items.push_back(tick_item());                                  // first own beacon
        pending_items.push_back(tick_item());                                  // inside period
        pending_items.push_back(beacon('1, 16'd5, 16'd1, 32'd7, 48'h1, 11'd12));
        pending_items.push_back(beacon('1, 16'd5, 16'd1, 32'd7, 48'h1, 11'd14));
        pending_items.push_back(beacon('1, 16'd5, 16'd1, 32'd7, 48'h1, 11'd0));
        pending_items.push_back(beacon('1, 16'd5, 16'd1, 32'd7, 48'h1, 11'd1500));
        pending_items.push_back(beacon(32'd1, 16'd5, 16'd1, 32'd7, 48'h1,
                                       mreb_pkg::VALID_BEACON_LEN));
        pending_items.push_back(beacon(32'd0, 16'd5, 16'd5, 32'd7, 48'h2,
                                       mreb_pkg::VALID_BEACON_LEN));
        pending_items.push_back(beacon(32'h8000_0000, 16'h0010, 16'd0, 32'd9, 48'h1234,
                                       mreb_pkg::VALID_BEACON_LEN));           // higher id taken
        pending_items.push_back(beacon(32'h8000_0000, 16'h0010, 16'd0, 32'd9, 48'h5,
                                       mreb_pkg::VALID_BEACON_LEN));           // equal seq
        pending_items.push_back(beacon(32'h8000_0000, 16'h800f, 16'd0, 32'd9, 48'h5,
                                       mreb_pkg::VALID_BEACON_LEN));           // half window away
        pending_items.push_back(beacon(32'h8000_0000, 16'h800e, 16'd0, 32'd9, 48'h6,
                                       mreb_pkg::VALID_BEACON_LEN));           // just newer
        pending_items.push_back(beacon(32'h8000_0000, 16'h000e, 16'd1, 32'd9, 48'h7,
                                       mreb_pkg::VALID_BEACON_LEN));           // newer, too long
        pending_items.push_back(beacon(32'h8000_0000, 16'h000e, 16'd0, 32'd1, 48'h8,
                                       mreb_pkg::VALID_BEACON_LEN));           // newer via wrap
        pending_items.push_back(beacon(32'd0, 16'd3, 16'd3, 32'd1, 48'h9,
                                       mreb_pkg::VALID_BEACON_LEN));
        pending_items.push_back(beacon('1, 16'hffff, 16'hffff, '1, '1,
                                       mreb_pkg::VALID_BEACON_LEN));
        pending_items.push_back(beacon('1, 16'h0000, 16'hffff, '1, '1,
                                       mreb_pkg::VALID_BEACON_LEN));
        repeat (6) pending_items.push_back(tick_item());                       // foreign root times out
        wait_drained();

        // low extremes of timeout and period, sender idles
        configure($urandom, 8'd1, 8'd1);
        write_reg(CFG_UNUSED_IDX, $urandom);
        send_idle_pct = 54;
        push_random(300);
        wait_drained();

        // high extremes, receiver stalls
        configure('1, 8'd255, 8'd255);
        send_idle_pct = 0;
        stall_pct = 54;
        push_random(300);
        wait_drained();

        // own id zero, both sides idle
        configure('0, 8'($urandom_range(2, 8)), 8'($urandom_range(1, 4)));
        send_idle_pct = 16;
        stall_pct = 16;
        push_random(300);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        configure($urandom, 8'd3, 8'd2);
        send_idle_pct = 0;
        stall_pct = 0;
        push_random(150);
        hold_req = 1'b1;
        wait_drained();

        // sender resumes after a full drain
        send_idle_pct = 16;
        stall_pct = 16;
        push_random(150);
        wait_drained();

        if (mismatches == 0)
            $display("tb_mesh_root_election_beacon: PASS");
        else
            $display("tb_mesh_root_election_beacon: FAIL");
        $finish;
    end

endmodule
